/* rtl/pse_pkg.sv */
`default_nettype none

package pse_pkg;

    localparam int SLOT_W      = 6;
    localparam int SAMPLE_W    = 24;
    localparam int STATUS_W    = 2;
    localparam int FACTOR_W    = 17;
    localparam int SLOTS_CFG_W = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 17;
    localparam int TDATA_W     = 32;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int SLOT_RANGE    = 2 ** SLOT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET  = 7'd64;
    localparam logic [FACTOR_W-1:0]    FACTOR_RESET = 17'd32768;
    localparam logic [FACTOR_W-1:0]    ONE_Q16      = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 1'b1;

    localparam logic CMD_INIT   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNINIT = 2'd2;

    typedef struct packed {
        logic [SLOTS_CFG_W-1:0] slots_in_use;
        logic [FACTOR_W-1:0]    smoothing_factor;
    } cfg_t;

    typedef struct packed {
        logic                cmd;
        logic [SLOT_W-1:0]   slot;
        logic [SAMPLE_W-1:0] sample;
        logic                out_of_range;
    } q_entry_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CHECK,
        BS_LOAD,
        BS_MUL,
        BS_ADD,
        BS_OUT
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/pse_ram.sv */
`default_nettype none

module pse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/pse_front.sv */
`default_nettype none

module pse_front #(
    parameter int MAX_SLOTS = pse_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pse_pkg::cfg_t                 cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [pse_pkg::SLOT_W-1:0]    s_slot,
    input  wire logic [pse_pkg::SAMPLE_W-1:0]  s_sample,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output pse_pkg::q_entry_t                  q_entry
);

    import pse_pkg::*;

    localparam logic [31:0] MAX_SLOTS_U = 32'(MAX_SLOTS);

    q_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    logic     push;
    logic     pop;
    q_entry_t new_entry;

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // range check here, the valid map is checked in order by the back end
    always_comb
    begin
        new_entry.cmd          = s_cmd;
        new_entry.slot         = s_slot;
        new_entry.sample       = s_sample;
        new_entry.out_of_range = ({1'b0, s_slot} >= cfg.slots_in_use)
                              || (32'(s_slot) >= MAX_SLOTS_U);
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/pse_back.sv */
`default_nettype none

module pse_back #(
    parameter int MAX_SLOTS = pse_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pse_pkg::cfg_t                 cfg,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire pse_pkg::q_entry_t             q_entry,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pse_pkg::SLOT_W-1:0]    m_slot,
    output logic      [pse_pkg::SAMPLE_W-1:0]  m_estimate,
    output logic      [pse_pkg::STATUS_W-1:0]  m_status
);

    import pse_pkg::*;

    localparam int TBL_DEPTH = (MAX_SLOTS < SLOT_RANGE) ? MAX_SLOTS : SLOT_RANGE;
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = DIFF_W + FACTOR_W + 1;

    back_state_t state_reg;
    back_state_t state_next;

    q_entry_t                  work_reg;
    logic [TBL_DEPTH-1:0]      valid_reg;
    logic [SAMPLE_W-1:0]       est_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [SAMPLE_W-1:0]       res_est_reg;
    logic [STATUS_W-1:0]       res_status_reg;
    logic                      out_valid_reg;
    logic [SLOT_W-1:0]         out_slot_reg;
    logic [SAMPLE_W-1:0]       out_est_reg;
    logic [STATUS_W-1:0]       out_status_reg;

    logic [AW-1:0]             addr;
    logic                      slot_valid;
    logic                      out_free;
    logic [FACTOR_W-1:0]       f_sat;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [PROD_W-1:0]  blended;
    logic [SAMPLE_W-1:0]       upd_est;
    logic [SAMPLE_W-1:0]       rd_data;

    logic                      ram_re;
    logic                      ram_we;
    logic [SAMPLE_W-1:0]       ram_wdata;
    logic                      set_valid;
    logic                      res_load;
    logic [SAMPLE_W-1:0]       res_est_d;
    logic [STATUS_W-1:0]       res_status_d;
    logic                      out_load;

    assign addr       = work_reg.slot[AW-1:0];
    assign slot_valid = valid_reg[addr];
    assign out_free   = !out_valid_reg || m_ready;
    assign f_sat      = (cfg.smoothing_factor > ONE_Q16) ? ONE_Q16 : cfg.smoothing_factor;

    // est + (sample - est) * f / 2^16, round half up
    assign rounded = (prod_reg + PROD_W'(32768)) >>> 16;
    assign blended = $signed(PROD_W'(est_reg)) + rounded;
    assign upd_est = blended[SAMPLE_W-1:0];

    pse_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(TBL_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(addr),
        .rdata(rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BS_CHECK;
                end
            end
            BS_CHECK:
            begin
                if (!work_reg.out_of_range && work_reg.cmd == CMD_UPDATE && slot_valid)
                begin
                    state_next = BS_LOAD;
                end
                else
                begin
                    state_next = BS_OUT;
                end
            end
            BS_LOAD: state_next = BS_MUL;
            BS_MUL:  state_next = BS_ADD;
            BS_ADD:  state_next = BS_OUT;
            BS_OUT:
            begin
                if (out_free)
                begin
                    state_next = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready      = 1'b0;
        ram_re       = 1'b0;
        ram_we       = 1'b0;
        ram_wdata    = work_reg.sample;
        set_valid    = 1'b0;
        res_load     = 1'b0;
        res_est_d    = '0;
        res_status_d = ST_OK;
        out_load     = 1'b0;
        case (state_reg)
            BS_IDLE:
            begin
                q_ready = 1'b1;
            end
            BS_CHECK:
            begin
                if (work_reg.out_of_range)
                begin
                    res_load     = 1'b1;
                    res_status_d = ST_RANGE;
                end
                else if (work_reg.cmd == CMD_INIT)
                begin
                    ram_we    = 1'b1;
                    set_valid = 1'b1;
                    res_load  = 1'b1;
                    res_est_d = work_reg.sample;
                end
                else if (!slot_valid)
                begin
                    res_load     = 1'b1;
                    res_status_d = ST_UNINIT;
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            BS_ADD:
            begin
                ram_we    = 1'b1;
                ram_wdata = upd_est;
                res_load  = 1'b1;
                res_est_d = upd_est;
            end
            BS_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (set_valid)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ready && q_valid)
        begin
            work_reg <= q_entry;
        end
        if (state_reg == BS_LOAD)
        begin
            est_reg  <= rd_data;
            diff_reg <= $signed({1'b0, work_reg.sample}) - $signed({1'b0, rd_data});
        end
        if (state_reg == BS_MUL)
        begin
            prod_reg <= diff_reg * $signed({1'b0, f_sat});
        end
        if (res_load)
        begin
            res_est_reg    <= res_est_d;
            res_status_reg <= res_status_d;
        end
        if (out_load)
        begin
            out_slot_reg   <= work_reg.slot;
            out_est_reg    <= res_est_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_slot     = out_slot_reg;
    assign m_estimate = out_est_reg;
    assign m_status   = out_status_reg;

    // a flagged result never carries an estimate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> out_est_reg == '0)
        else $error("flagged result with nonzero estimate");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_status_reg == ST_OK || out_status_reg == ST_RANGE
                       || out_status_reg == ST_UNINIT)
        else $error("undefined status code");

    // the blend lies between the old estimate and the sample
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BS_ADD |->
            (upd_est >= est_reg || upd_est >= work_reg.sample)
         && (upd_est <= est_reg || upd_est <= work_reg.sample))
        else $error("blended estimate outside its bounds");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> state_reg == BS_LOAD)
        else $error("table read without a load cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !work_reg.out_of_range)
        else $error("table written for an out-of-range slot");

endmodule

`default_nettype wire

/* rtl/per_slot_ewma_predictor_unit.sv */
// per-slot smoothed load predictor
// s_* stream: one beat per command; s_tuser is the command (initialise or
// update), s_tdata carries the slot and a Q16.8 sample
// m_* stream: one beat per command, in order; s_tdata layout mirrored by
// slot and new estimate, m_tuser carries the status (ok, slot out of range,
// slot not initialised)
// cfg_*: register writes, always ready; index 0 slots in use, index 1 the
// Q1.16 smoothing factor
// an initialise or flagged command is answered straight from the check; an update
// first goes through table read, multiply, add and write
// the execute stage takes one command at a time; a four-entry queue after the
// range check takes beats while it works
// reset clears the valid map at once, sets slots in use to 64 and the factor
// to one half, and empties the queue and the output register
// when the receiver stalls the result register holds, the execute stage waits,
// and s_tready falls once the queue is full
`default_nettype none

module per_slot_ewma_predictor_unit #(
    parameter int MAX_SLOTS = pse_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [5:0] slot, [29:6] sample, [31:30] zero
    input  wire logic [pse_pkg::TDATA_W-1:0]     s_tdata,
    // [0] cmd
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [5:0] slot_out, [29:6] estimate, [31:30] zero
    output logic      [pse_pkg::TDATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic      [pse_pkg::STATUS_W-1:0]    m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pse_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import pse_pkg::*;

    logic [SLOTS_CFG_W-1:0] slots_reg;
    logic [FACTOR_W-1:0]    factor_reg;
    cfg_t                   cfg;

    logic                   q_valid;
    logic                   q_ready;
    q_entry_t               q_entry;

    logic [SLOT_W-1:0]      res_slot;
    logic [SAMPLE_W-1:0]    res_est;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg  <= SLOTS_RESET;
            factor_reg <= FACTOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SLOTS:  slots_reg  <= cfg_data[SLOTS_CFG_W-1:0];
                REG_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.slots_in_use     = slots_reg;
        cfg.smoothing_factor = factor_reg;
    end

    pse_front #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_cmd   (s_tuser),
        .s_slot  (s_tdata[SLOT_W-1:0]),
        .s_sample(s_tdata[SLOT_W+SAMPLE_W-1:SLOT_W]),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry)
    );

    pse_back #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_slot    (res_slot),
        .m_estimate(res_est),
        .m_status  (m_tuser)
    );

    assign m_tdata = {{(TDATA_W - SLOT_W - SAMPLE_W){1'b0}}, res_est, res_slot};

endmodule

`default_nettype wire

/* tb/per_slot_ewma_predictor_unit_tb.sv */
`default_nettype none

module per_slot_ewma_predictor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pse_pkg::*;

    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic [SAMPLE_W-1:0] estimate;
        logic [STATUS_W-1:0] status;
    } estimate_result_t;

    class estimate_scoreboard;
        logic [SAMPLE_W-1:0]    est_table [MAX_SLOTS_DEF];
        bit                     valid_map [MAX_SLOTS_DEF];
        logic [SLOTS_CFG_W-1:0] slots_cfg;
        logic [FACTOR_W-1:0]    factor_cfg;
        estimate_result_t       due_q [$];
        int errors, commands, results, range_hits, uninit_hits, reg_writes;

        function new();
            slots_cfg  = SLOTS_RESET;
            factor_cfg = FACTOR_RESET;
            foreach (valid_map[i])
            begin
                valid_map[i] = 1'b0;
                est_table[i] = '0;
            end
        endfunction

        // rounded blend of old estimate and sample, factor saturated at one
        function logic [SAMPLE_W-1:0] blend_estimate(logic [SAMPLE_W-1:0] old_est,
                                                     logic [SAMPLE_W-1:0] smp,
                                                     logic [FACTOR_W-1:0] f);
            logic [63:0] w;
            logic [63:0] acc;
            w   = (f > ONE_Q16) ? 64'(ONE_Q16) : 64'(f);
            acc = 64'(old_est) * (64'(ONE_Q16) - w) + 64'(smp) * w + 64'd32768;
            return acc[16 +: SAMPLE_W];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            reg_writes++;
            if (idx == REG_SLOTS)
                slots_cfg = value[SLOTS_CFG_W-1:0];
            else if (idx == REG_FACTOR)
                factor_cfg = value[FACTOR_W-1:0];
        endfunction

        function void note_command(logic c, logic [SLOT_W-1:0] sl, logic [SAMPLE_W-1:0] smp);
            estimate_result_t r;
            r.slot     = sl;
            r.estimate = '0;
            r.status   = ST_OK;
            commands++;
            if ({1'b0, sl} >= slots_cfg)
            begin
                r.status = ST_RANGE;
                range_hits++;
            end
            else if (c == CMD_INIT)
            begin
                est_table[sl] = smp;
                valid_map[sl] = 1'b1;
                r.estimate    = smp;
            end
            else if (!valid_map[sl])
            begin
                r.status = ST_UNINIT;
                uninit_hits++;
            end
            else
            begin
                r.estimate    = blend_estimate(est_table[sl], smp, factor_cfg);
                est_table[sl] = r.estimate;
            end
            due_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(logic [TDATA_W-1:0] data, logic [STATUS_W-1:0] st);
            estimate_result_t r;
            results++;
            if (due_q.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result beat, expected none, actual slot %0d",
                             $time, data[SLOT_W-1:0]);
                return;
            end
            r = due_q.pop_front();
            compare_field("slot", r.slot, data[SLOT_W-1:0]);
            compare_field("estimate", r.estimate, data[SLOT_W +: SAMPLE_W]);
            compare_field("status", r.status, st);
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    estimate_scoreboard board = new();
    bit hold_request = 1'b0;
    bit no_idle      = 1'b0;

    per_slot_ewma_predictor_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = 250;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // leaves s_tvalid high; the caller lowers it through a pause or a settle
    task automatic push_command(input logic c, input logic [SLOT_W-1:0] sl,
                                input logic [SAMPLE_W-1:0] smp);
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {{(TDATA_W - SLOT_W - SAMPLE_W){1'b0}}, smp, sl};
        do @(posedge clk); while (!s_tready);
        board.note_command(c, sl, smp);
    endtask

    task automatic maybe_pause();
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // wait for every expected beat, then give an update time to retire
    task automatic settle();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic configure(input int unsigned slots, input int unsigned factor);
        settle();
        write_register(REG_SLOTS, slots);
        write_register(REG_FACTOR, factor);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly in-range slots, updates mostly on initialised slots, repeats of the last slot
    task automatic random_commands(input int count, input bit pausing);
        int                  k;
        int                  lim;
        logic [SLOT_W-1:0]   sl;
        logic [SLOT_W-1:0]   last_slot;
        logic                c;
        logic [SAMPLE_W-1:0] smp;
        last_slot = '0;
        lim = (board.slots_cfg > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(board.slots_cfg);
        for (k = 0; k < count; k++)
        begin
            if (lim > 0 && $urandom_range(0, 99) < 88)
            begin
                if ($urandom_range(0, 99) < 30 && last_slot < lim)
                    sl = last_slot;
                else
                    sl = SLOT_W'($urandom_range(0, lim - 1));
            end
            else
                sl = SLOT_W'($urandom_range(0, SLOT_RANGE - 1));
            if (board.valid_map[sl])
                c = ($urandom_range(0, 99) < 80) ? CMD_UPDATE : CMD_INIT;
            else
                c = ($urandom_range(0, 99) < 15) ? CMD_UPDATE : CMD_INIT;
            case ($urandom_range(0, 9))
                0: smp = '0;
                1: smp = '1;
                default: smp = SAMPLE_W'($urandom_range(0, 24'hFFFFFF));
            endcase
            push_command(c, sl, smp);
            if (pausing)
                maybe_pause();
            last_slot = sl;
        end
    endtask

    initial
    begin
        int ph;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_INIT;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SLOTS;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 64 slots, factor one half
        push_command(CMD_UPDATE, 6'd7, 24'h123456);
        push_command(CMD_INIT, 6'd0, 24'h000000);
        push_command(CMD_INIT, 6'd63, 24'hFFFFFF);
        push_command(CMD_UPDATE, 6'd63, 24'h000000);
        push_command(CMD_UPDATE, 6'd0, 24'hFFFFFF);
        push_command(CMD_INIT, 6'd21, 24'hAAAAAA);
        push_command(CMD_UPDATE, 6'd21, 24'h555555);
        push_command(CMD_UPDATE, 6'd21, 24'h555555);
        push_command(CMD_UPDATE, 6'd21, 24'hFFFFFF);
        push_command(CMD_INIT, 6'd42, 24'h0F0F0F);
        push_command(CMD_UPDATE, 6'd42, 24'h0F0F0F);

        // factor above one saturates; shrunk slot count puts valid slots out of range
        configure(10, 131071);
        push_command(CMD_UPDATE, 6'd21, 24'h000001);
        push_command(CMD_INIT, 6'd10, 24'h00FF00);
        push_command(CMD_UPDATE, 6'd40, 24'h000100);
        push_command(CMD_UPDATE, 6'd63, 24'h000100);

        configure(0, 0);
        push_command(CMD_INIT, 6'd0, 24'h000010);

        // slot 63 comes back with its old estimate, factor zero keeps it
        configure(64, 0);
        push_command(CMD_UPDATE, 6'd63, 24'hFFFFFF);

        configure(64, 65536);
        push_command(CMD_UPDATE, 6'd0, 24'h000000);

        configure(1, 1);
        push_command(CMD_UPDATE, 6'd0, 24'hFFFFFF);
        push_command(CMD_INIT, 6'd1, 24'h000001);

        for (ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                no_idle = 1'b1;
            case (ph)
                0: configure(64, $urandom_range(1, 65535));
                1: configure(1, 65536);
                2: configure(16, 0);
                3: configure(64, 131071);
                4: configure(33, 1);
                5: configure(127, 65535);
                6: configure(2, $urandom_range(0, 131071));
                default: configure(64, $urandom_range(0, 131071));
            endcase
            if (ph == 3)
            begin
                // long receiver hold-off while beats keep coming
                hold_request = 1'b1;
                random_commands(40, 1'b0);
            end
            random_commands(200, 1'b1);
        end

        settle();
        $display("covered %0d commands, %0d out of range and %0d before initialise",
                 board.commands, board.range_hits, board.uninit_hits);
        $display("%0d register writes, %0d result beats compared, %0d mismatches",
                 board.reg_writes, board.results, board.errors);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/pse_pkg.sv
rtl/pse_ram.sv
rtl/pse_front.sv
rtl/pse_back.sv
rtl/per_slot_ewma_predictor_unit.sv
tb/per_slot_ewma_predictor_unit_tb.sv
